// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  localparam int unsigned PATTERN_MAX = 12;
  localparam int unsigned STEM_MAX    = 8;
  localparam int unsigned SUFFIX_MAX  = 3;

  localparam int unsigned NCELL     = PATTERN_MAX + 1;
  localparam int unsigned PAT_LEN_W = 4;
  localparam int unsigned STEM_W    = $clog2(STEM_MAX + 1);
  localparam int unsigned SUFFIX_W  = $clog2(SUFFIX_MAX + 1);
  localparam int unsigned DOTS_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  localparam logic [DOTS_W-1:0] DOTS_NONE = 2'd0;
  localparam logic [DOTS_W-1:0] DOTS_ONE  = 2'd1;
  localparam logic [DOTS_W-1:0] DOTS_TWO  = 2'd2;
  localparam logic [DOTS_W-1:0] DOTS_DONE = 2'd3;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
  } swm_in_t;

  typedef struct packed {
    logic is_match;
    logic name_fits;
  } swm_out_t;

  // Signals handed from one pattern-position cell to the next.
  typedef struct packed {
    logic en;
    logic cur_star;
    logic adv;
    logic fin_star;
    logic emp_star;
  } swm_link_t;

endpackage

// ===== rtl/swm_cell.sv =====
module swm_cell import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      fresh_i,
  input  logic      init_i,
  input  logic      en_i,
  input  logic [7:0] pat_byte_i,
  input  logic [7:0] name_byte_i,
  input  swm_link_t link_i,
  output swm_link_t link_o,
  output logic      match_o,
  output logic      empty_o
);

  logic act_q, act_d;
  logic act, cur, nxt, fin, emp, star, hit, at_end;

  assign star   = (pat_byte_i == CH_STAR);
  assign hit    = (pat_byte_i == CH_QUEST) || (pat_byte_i == name_byte_i);
  assign act    = fresh_i ? init_i : act_q;
  assign cur    = act | link_i.cur_star;
  assign nxt    = (en_i & cur & star) | link_i.adv;
  assign fin    = nxt | link_i.fin_star;
  assign emp    = init_i | link_i.emp_star;
  assign at_end = link_i.en & ~en_i;

  assign link_o.en       = en_i;
  assign link_o.cur_star = en_i & cur & star;
  assign link_o.adv      = en_i & cur & ~star & hit;
  assign link_o.fin_star = en_i & fin & star;
  assign link_o.emp_star = en_i & emp & star;

  assign match_o = at_end & fin;
  assign empty_o = at_end & emp;

  assign act_d = step_i ? nxt : act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

endmodule

// ===== rtl/swm_form.sv =====
module swm_form import swm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       last_i,
  input  logic [7:0] name_byte_i,
  output logic       fits_o
);

  logic [STEM_W-1:0]   stem_q, stem_d;
  logic [SUFFIX_W-1:0] suffix_q, suffix_d;
  logic                in_suffix_q, in_suffix_d;
  logic                broken_q, broken_d;
  logic [DOTS_W-1:0]   dots_q, dots_d;
  logic                is_dot;

  assign is_dot = (name_byte_i == CH_DOT);

  always_comb begin
    stem_d      = stem_q;
    suffix_d    = suffix_q;
    in_suffix_d = in_suffix_q;
    broken_d    = broken_q;
    if (is_dot && dots_q != DOTS_DONE) begin
      dots_d = dots_q + DOTS_W'(1);
    end else begin
      dots_d = DOTS_DONE;
    end
    if (!broken_q) begin
      if (dots_q == DOTS_NONE && is_dot) begin
        broken_d = 1'b1;
      end else if (!in_suffix_q) begin
        if (is_dot) begin
          in_suffix_d = 1'b1;
        end else if (stem_q >= STEM_W'(STEM_MAX)) begin
          broken_d = 1'b1;
        end else begin
          stem_d = stem_q + STEM_W'(1);
        end
      end else begin
        if (suffix_q >= SUFFIX_W'(SUFFIX_MAX)) begin
          broken_d = 1'b1;
        end else begin
          suffix_d = suffix_q + SUFFIX_W'(1);
        end
      end
    end
  end

  assign fits_o = !broken_d || dots_d == DOTS_ONE || dots_d == DOTS_TWO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stem_q      <= '0;
      suffix_q    <= '0;
      in_suffix_q <= 1'b0;
      broken_q    <= 1'b0;
      dots_q      <= DOTS_NONE;
    end else if (step_i) begin
      if (last_i) begin
        stem_q      <= '0;
        suffix_q    <= '0;
        in_suffix_q <= 1'b0;
        broken_q    <= 1'b0;
        dots_q      <= DOTS_NONE;
      end else begin
        stem_q      <= stem_d;
        suffix_q    <= suffix_d;
        in_suffix_q <= in_suffix_d;
        broken_q    <= broken_d;
        dots_q      <= dots_d;
      end
    end
  end

endmodule

// ===== rtl/short_name_wildcard_match.sv =====
// Short-name check and wildcard match over a stream of name bytes.
// Items enter on the in channel (valid/ready), one name byte per item, the
// final byte of a name flagged by last_byte. Only the final byte produces a
// result on the out channel (valid/ready): is_match and name_fits.
// The pattern is written through the cfg channel (valid/ready, always ready)
// by the user only while no name is in progress; the block does not enforce
// this. Index 0 holds pattern bytes 0 to 7, index 1 bytes 8 to 11, index 2 the
// pattern length. A row of thirteen cells, one per pattern position, holds the
// active position set; every cell updates in the same cycle, so one byte is
// taken per clock unless held off. The result is registered and appears in
// the cycle after the final byte is accepted. A new byte is accepted while
// the result register is empty or is being emptied in the same cycle, so a
// stalled receiver holds off the input only while a result is waiting.
// Reset clears the pattern registers, the name state and out_valid.
module short_name_wildcard_match import swm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  swm_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output swm_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [63:0]          pat_low_q;
  logic [31:0]          pat_high_q;
  logic [PAT_LEN_W-1:0] pat_len_q;
  logic [PAT_LEN_W-1:0] len_clip;
  logic [8*NCELL-1:0]   pat_all;
  logic [7:0]           pat_byte [NCELL];
  logic [NCELL-1:0]     en_raw, en;
  swm_link_t            link [NCELL+1];
  logic [NCELL-1:0]     match_vec, empty_vec;
  logic                 fresh_q;
  logic                 step, fits;
  logic                 out_valid_q;
  swm_out_t             out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i[31:0];
        REG_PAT_LEN:  pat_len_q  <= cfg_data_i[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_clip = (pat_len_q > PAT_LEN_W'(PATTERN_MAX)) ? PAT_LEN_W'(PATTERN_MAX) : pat_len_q;
  assign pat_all  = {8'h00, pat_high_q, pat_low_q};

  always_comb begin
    for (int p = 0; p < NCELL; p++) begin
      pat_byte[p] = pat_all[8*p +: 8];
      en_raw[p]   = (PAT_LEN_W'(p) < len_clip) && (pat_byte[p] != 8'h00);
    end
    en[0] = en_raw[0];
    for (int p = 1; p < NCELL; p++) begin
      en[p] = en_raw[p] & en[p-1];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  assign link[0] = '{en: 1'b1, cur_star: 1'b0, adv: 1'b0, fin_star: 1'b0, emp_star: 1'b0};

  for (genvar p = 0; p < NCELL; p++) begin : g_cell
    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .fresh_i     (fresh_q),
      .init_i      (p == 0),
      .en_i        (en[p]),
      .pat_byte_i  (pat_byte[p]),
      .name_byte_i (in_data_i.name_byte),
      .link_i      (link[p]),
      .link_o      (link[p+1]),
      .match_o     (match_vec[p]),
      .empty_o     (empty_vec[p])
    );
  end

  swm_form u_form (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .last_i      (in_data_i.last_byte),
    .name_byte_i (in_data_i.name_byte),
    .fits_o      (fits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= 1'b1;
    end else if (step) begin
      fresh_q <= in_data_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_data_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_data_i.last_byte) begin
      out_data_q.is_match  <= fits ? (|match_vec) : (|empty_vec);
      out_data_q.name_fits <= fits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== tb/name_match_checker.sv =====
// Watches all three channels, keeps its own copy of the pattern and the name state, and checks
// every result against the verdict predicted for the name that produced it.
module name_match_checker import swm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  swm_in_t               in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  swm_out_t              out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    outstanding_o,
  output int                    names_o,
  output int                    matched_o,
  output int                    unfit_o
);

  logic [63:0]          pat_low;
  logic [31:0]          pat_high;
  logic [PAT_LEN_W-1:0] pat_len;

  logic [NCELL-1:0]     live;
  logic [STEM_W-1:0]    stem_n;
  logic [SUFFIX_W-1:0]  sfx_n;
  logic                 dot_seen;
  logic                 broken;
  logic [DOTS_W-1:0]    dot_run;

  swm_out_t verdict_q[$];

  function automatic logic [7:0] pattern_at(int unsigned i);
    if (i < 8) return pat_low[8*i +: 8];
    if (i < 12) return pat_high[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  // The pattern stops at the configured length, capped, or at its first zero byte.
  function automatic int unsigned pattern_span();
    int unsigned n;
    n = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    for (int unsigned i = 0; i < n; i++) begin
      if (pattern_at(i) == 8'h00) return i;
    end
    return n;
  endfunction

  function automatic logic [NCELL-1:0] star_closure(logic [NCELL-1:0] set, int unsigned n);
    for (int unsigned p = 0; p < n; p++) begin
      if (set[p] && pattern_at(p) == CH_STAR) set[p+1] = 1'b1;
    end
    return set;
  endfunction

  task automatic clear_name();
    live     = NCELL'(1);
    stem_n   = '0;
    sfx_n    = '0;
    dot_seen = 1'b0;
    broken   = 1'b0;
    dot_run  = DOTS_NONE;
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic take_name_byte(logic [7:0] c, logic fin);
    int unsigned      n;
    logic [NCELL-1:0] cur;
    logic [NCELL-1:0] nxt;
    logic [NCELL-1:0] fin_set;
    logic [7:0]       pc;
    logic             first;
    logic             fits;
    swm_out_t         v;
    n = pattern_span();
    cur = star_closure(live, n);
    nxt = '0;
    first = (dot_run == DOTS_NONE);
    for (int unsigned p = 0; p < n; p++) begin
      if (cur[p]) begin
        pc = pattern_at(p);
        if (pc == CH_STAR) nxt[p] = 1'b1;
        else if (pc == CH_QUEST || pc == c) nxt[p+1] = 1'b1;
      end
    end
    live = nxt;

    if (c == CH_DOT) begin
      if (dot_run != DOTS_DONE) dot_run = dot_run + 1'b1;
    end else begin
      dot_run = DOTS_DONE;
    end

    if (!broken) begin
      if (first && c == CH_DOT) begin
        broken = 1'b1;
      end else if (!dot_seen) begin
        if (c == CH_DOT) dot_seen = 1'b1;
        else if (stem_n >= STEM_MAX) broken = 1'b1;
        else stem_n = stem_n + 1'b1;
      end else if (sfx_n >= SUFFIX_MAX) begin
        broken = 1'b1;
      end else begin
        sfx_n = sfx_n + 1'b1;
      end
    end

    if (fin) begin
      // A name outside the short form is matched as the empty name.
      fits = !broken || dot_run == DOTS_ONE || dot_run == DOTS_TWO;
      fin_set = fits ? star_closure(live, n) : star_closure(NCELL'(1), n);
      v.is_match = fin_set[n];
      v.name_fits = fits;
      verdict_q.push_back(v);
      clear_name();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    swm_out_t want;
    if (!rst_ni) begin
      pat_low = '0;
      pat_high = '0;
      pat_len = '0;
      clear_name();
      verdict_q.delete();
      errors_o = 0;
      names_o = 0;
      matched_o = 0;
      unfit_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result arrived with no name pending");
        end else begin
          want = verdict_q.pop_front();
          if (out_data_i.is_match !== want.is_match)
            report_mismatch($sformatf("is_match expected %0b got %0b",
                                      want.is_match, out_data_i.is_match));
          if (out_data_i.name_fits !== want.name_fits)
            report_mismatch($sformatf("name_fits expected %0b got %0b",
                                      want.name_fits, out_data_i.name_fits));
          names_o++;
          if (want.is_match) matched_o++;
          if (!want.name_fits) unfit_o++;
        end
      end
      if (in_valid_i && in_ready_i) take_name_byte(in_data_i.name_byte, in_data_i.last_byte);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_PAT_LOW:  pat_low = cfg_data_i;
          REG_PAT_HIGH: pat_high = cfg_data_i[31:0];
          REG_PAT_LEN:  pat_len = cfg_data_i[PAT_LEN_W-1:0];
          default: ;
        endcase
      end
      outstanding_o = verdict_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import swm_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  swm_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  swm_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int outstanding;
  int names_seen;
  int names_matched;
  int names_unfit;

  int unsigned bytes_sent = 0;
  int unsigned settings_used = 0;
  int unsigned hold_cycles = 0;
  bit          sender_idles = 1'b0;
  bit          receiver_stalls = 1'b0;

  logic [7:0]  pat_copy[12];
  int unsigned pat_used = 0;
  logic [7:0]  name_buf[$];

  always #1 clk = ~clk;

  short_name_wildcard_match dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  name_match_checker u_match_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .names_o       (names_seen),
    .matched_o     (names_matched),
    .unfit_o       (names_unfit)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] make_char();
    logic [7:0] c;
    if ($urandom_range(0, 1)) c = 8'h41 + 8'($urandom_range(0, 2));
    else c = 8'($urandom_range(1, 255));
    if (c == CH_DOT) c = 8'h5A;
    return c;
  endfunction

  function automatic logic [7:0] pattern_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 6) return CH_STAR;
    if (r < 10) return CH_QUEST;
    if (r < 15) return 8'h41 + 8'($urandom_range(0, 2));
    if (r < 17) return CH_DOT;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(logic [7:0] b, logic fin);
    int unsigned gap;
    gap = sender_idles ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.name_byte = b;
    in_data.last_byte = fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_name();
    for (int i = 0; i < name_buf.size(); i++) send_byte(name_buf[i], i == name_buf.size() - 1);
  endtask

  // Stops offering items and waits until every pending result is back.
  task automatic drain(int unsigned extra);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_pattern(logic [63:0] lo, logic [31:0] hi, logic [PAT_LEN_W-1:0] len);
    int unsigned n;
    drain(4);
    write_reg(REG_PAT_LOW, lo);
    write_reg(REG_PAT_HIGH, {32'h0, hi});
    write_reg(REG_PAT_LEN, {{(CFG_DATA_W-PAT_LEN_W){1'b0}}, len});
    for (int i = 0; i < 8; i++) pat_copy[i] = lo[8*i +: 8];
    for (int i = 0; i < 4; i++) pat_copy[8+i] = hi[8*i +: 8];
    n = (len > 12) ? 12 : len;
    pat_used = n;
    for (int i = n - 1; i >= 0; i--) begin
      if (pat_copy[i] == 8'h00) pat_used = i;
    end
    settings_used++;
  endtask

  task automatic build_name();
    int unsigned r;
    int unsigned k;
    name_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      // Fill in the current pattern so that most of these names match.
      for (int i = 0; i < pat_used; i++) begin
        if (pat_copy[i] == CH_STAR) begin
          repeat ($urandom_range(0, 2)) name_buf.push_back(make_char());
        end else if (pat_copy[i] == CH_QUEST) begin
          name_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
          name_buf.push_back(pat_copy[i]);
        end
      end
      if (name_buf.size() == 0) name_buf.push_back(make_char());
    end else if (r < 65) begin
      repeat ($urandom_range(1, STEM_MAX)) name_buf.push_back(make_char());
      if ($urandom_range(0, 2) != 0) begin
        name_buf.push_back(CH_DOT);
        repeat ($urandom_range(0, SUFFIX_MAX)) name_buf.push_back(8'($urandom_range(1, 255)));
      end
    end else if (r < 75) begin
      repeat ($urandom_range(1, 3)) name_buf.push_back(CH_DOT);
      if ($urandom_range(0, 2) == 0) name_buf.push_back(make_char());
    end else if (r < 87) begin
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(STEM_MAX + 1, STEM_MAX + 3)) name_buf.push_back(make_char());
      end else begin
        repeat ($urandom_range(1, STEM_MAX)) name_buf.push_back(make_char());
        name_buf.push_back(CH_DOT);
        k = $urandom_range(SUFFIX_MAX + 1, SUFFIX_MAX + 2);
        repeat (k) name_buf.push_back(make_char());
      end
    end else begin
      repeat ($urandom_range(1, 14)) name_buf.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_ready = 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (pick_gap() + 1) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    int unsigned phase_items;
    logic [63:0] lo;
    logic [31:0] hi;
    logic [3:0]  ln;
    bit          paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PAT_LOW;
    cfg_data = '0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty pattern after reset: dot names, a leading dot, and the byte extremes.
    send_text(".");
    send_text("..");
    send_text("...");
    send_text(".A");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);

    // Oversized length and a zero byte cutting the pattern short to A?*.
    set_pattern(64'h0000_0042_002A_3F41, 32'hFFFF_FFFF, 4'hF);
    send_text("AB");
    send_text("A.C..");
    send_text("ABCDEFGHI");

    for (int ph = 0; ph < 16; ph++) begin
      case (ph)
        0: set_pattern('1, '1, 4'hF);
        1: set_pattern({8{CH_STAR}}, {4{CH_STAR}}, 4'd12);
        2: set_pattern({40'h0, CH_STAR, CH_DOT, CH_STAR}, 32'h0, 4'd3);
        3: set_pattern({8{CH_QUEST}}, {4{CH_QUEST}}, 4'd12);
        4: set_pattern('0, '0, 4'd12);
        5: set_pattern({8{CH_QUEST}}, {CH_QUEST, CH_QUEST, CH_QUEST, CH_DOT}, 4'd12);
        default: begin
          for (int i = 0; i < 8; i++) lo[8*i +: 8] = pattern_char();
          for (int i = 0; i < 4; i++) hi[8*i +: 8] = pattern_char();
          if ($urandom_range(0, 9) == 0) begin
            ln = ($urandom_range(0, 1)) ? 4'd0 : 4'($urandom_range(13, 15));
          end else begin
            ln = 4'($urandom_range(1, 12));
          end
          set_pattern(lo, hi, ln);
        end
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // Results are held back while names keep coming, so the input backs up.
        sender_idles = 1'b0;
        @(posedge clk);
        hold_cycles = 80;
      end
      phase_items = 0;
      while (phase_items < 68) begin
        if (ph == 8 && !paused && phase_items >= 36) begin
          drain(0);
          paused = 1'b1;
        end
        build_name();
        send_name();
        phase_items += name_buf.size();
      end
    end

    drain(8);
    $display("Covered %0d name bytes in %0d names under %0d pattern settings.",
             bytes_sent, names_seen, settings_used);
    $display("%0d names matched their pattern and %0d fell outside the short form.",
             names_matched, names_unfit);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/swm_form.sv
rtl/short_name_wildcard_match.sv
tb/name_match_checker.sv
tb/testbench.sv
